// ===== hw/rtl/cpu8_pkg.sv =====
package cpu8_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0, OP_SBC = 6'd1, OP_AND = 6'd2, OP_ORA = 6'd3, OP_EOR = 6'd4,
		OP_CMP = 6'd5, OP_CPX = 6'd6, OP_CPY = 6'd7, OP_BIT = 6'd8, OP_LDA = 6'd9,
		OP_LDX = 6'd10, OP_LDY = 6'd11, OP_ASL = 6'd12, OP_LSR = 6'd13, OP_ROL = 6'd14,
		OP_ROR = 6'd15, OP_INC = 6'd16, OP_DEC = 6'd17, OP_INX = 6'd18, OP_INY = 6'd19,
		OP_DEX = 6'd20, OP_DEY = 6'd21, OP_TAX = 6'd22, OP_TAY = 6'd23, OP_TSX = 6'd24,
		OP_TXA = 6'd25, OP_TXS = 6'd26, OP_TYA = 6'd27, OP_CLC = 6'd28, OP_CLD = 6'd29,
		OP_CLI = 6'd30, OP_CLV = 6'd31, OP_SEC = 6'd32, OP_SED = 6'd33, OP_SEI = 6'd34,
		OP_BCC = 6'd35, OP_BCS = 6'd36, OP_BEQ = 6'd37, OP_BNE = 6'd38, OP_BMI = 6'd39,
		OP_BPL = 6'd40, OP_BVC = 6'd41, OP_BVS = 6'd42, OP_JMP = 6'd43, OP_JSR = 6'd44,
		OP_RTS = 6'd45, OP_RTI = 6'd46, OP_BRK = 6'd47, OP_PHA = 6'd48, OP_PHP = 6'd49,
		OP_PLA = 6'd50, OP_PLP = 6'd51, OP_STA = 6'd52, OP_STX = 6'd53, OP_STY = 6'd54,
		OP_NOP = 6'd55
	} op_t;

	typedef enum logic [1:0] {
		REG_BRK_VEC = 2'd0,
		REG_RST_VEC = 2'd1,
		REG_STOP    = 2'd2
	} reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STACK,
		ST_DONE
	} state_t;

	localparam logic [7:0] F_C = 8'h01;
	localparam logic [7:0] F_Z = 8'h02;
	localparam logic [7:0] F_I = 8'h04;
	localparam logic [7:0] F_D = 8'h08;
	localparam logic [7:0] F_B = 8'h10;
	localparam logic [7:0] F_V = 8'h40;
	localparam logic [7:0] F_N = 8'h80;

	// architectural registers
	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
	} regs_t;

	// combinational ALU result for instructions that do not touch the stack
	typedef struct packed {
		regs_t      regs;
		logic       we;
		logic [7:0] wd;
	} alu_res_t;

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p & ~(F_Z | F_N);
		if (v == 8'd0)
			r = r | F_Z;
		r = r | (v & F_N);
		return r;
	endfunction

endpackage

// ===== hw/rtl/cpu8_alu.sv =====
module cpu8_alu
	import cpu8_pkg::*;
(
	input  regs_t       regs,
	input  logic [5:0]  cmd,
	input  logic [7:0]  operand,
	input  logic [15:0] jump_target,
	input  logic [15:0] next_pc,
	input  logic        on_memory,
	output alu_res_t    res
);

	logic [8:0] sum;
	logic [7:0] addend;
	logic [7:0] cmp_reg;
	logic [8:0] diff;
	logic [7:0] sh_in;
	logic [7:0] sh_out;
	logic       sh_c;
	logic       take;
	logic [7:0] p;

	always_comb begin
		res = '{regs: regs, we: 1'b0, wd: 8'd0};
		res.regs.pc = next_pc;
		p = regs.p;
		take = 1'b0;
		addend = (cmd == OP_SBC) ? ~operand : operand;
		sum = {1'b0, regs.a} + {1'b0, addend} + {8'd0, regs.p[0]};
		cmp_reg = (cmd == OP_CPX) ? regs.x : ((cmd == OP_CPY) ? regs.y : regs.a);
		diff = {1'b0, cmp_reg} - {1'b0, operand};
		sh_in = on_memory ? operand : regs.a;
		sh_out = 8'd0;
		sh_c = 1'b0;
		case (cmd)
			OP_ASL: begin sh_out = {sh_in[6:0], 1'b0};      sh_c = sh_in[7]; end
			OP_LSR: begin sh_out = {1'b0, sh_in[7:1]};      sh_c = sh_in[0]; end
			OP_ROL: begin sh_out = {sh_in[6:0], regs.p[0]}; sh_c = sh_in[7]; end
			default: begin sh_out = {regs.p[0], sh_in[7:1]}; sh_c = sh_in[0]; end
		endcase

		unique case (cmd) inside
			OP_ADC, OP_SBC: begin
				res.regs.a = sum[7:0];
				p[6] = ((regs.a ^ sum[7:0]) & (addend ^ sum[7:0]) & 8'h80) != 8'd0;
				p[0] = sum[8];
				p = set_nz(p, sum[7:0]);
			end
			OP_AND: begin res.regs.a = regs.a & operand; p = set_nz(p, regs.a & operand); end
			OP_ORA: begin res.regs.a = regs.a | operand; p = set_nz(p, regs.a | operand); end
			OP_EOR: begin res.regs.a = regs.a ^ operand; p = set_nz(p, regs.a ^ operand); end
			OP_CMP, OP_CPX, OP_CPY: begin
				p[0] = ~diff[8];
				p[1] = (cmp_reg == operand);
				p[7] = diff[7];
			end
			OP_BIT: begin
				p[1] = ((regs.a & operand) == 8'd0);
				p[6] = operand[6];
				p[7] = operand[7];
			end
			OP_LDA: begin res.regs.a = operand; p = set_nz(p, operand); end
			OP_LDX: begin res.regs.x = operand; p = set_nz(p, operand); end
			OP_LDY: begin res.regs.y = operand; p = set_nz(p, operand); end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				p[0] = sh_c;
				p = set_nz(p, sh_out);
				if (on_memory) begin
					res.we = 1'b1;
					res.wd = sh_out;
				end else begin
					res.regs.a = sh_out;
				end
			end
			OP_INC: begin res.we = 1'b1; res.wd = operand + 8'd1; p = set_nz(p, operand + 8'd1); end
			OP_DEC: begin res.we = 1'b1; res.wd = operand - 8'd1; p = set_nz(p, operand - 8'd1); end
			OP_INX: begin res.regs.x = regs.x + 8'd1; p = set_nz(p, regs.x + 8'd1); end
			OP_INY: begin res.regs.y = regs.y + 8'd1; p = set_nz(p, regs.y + 8'd1); end
			OP_DEX: begin res.regs.x = regs.x - 8'd1; p = set_nz(p, regs.x - 8'd1); end
			OP_DEY: begin res.regs.y = regs.y - 8'd1; p = set_nz(p, regs.y - 8'd1); end
			OP_TAX: begin res.regs.x = regs.a; p = set_nz(p, regs.a); end
			OP_TAY: begin res.regs.y = regs.a; p = set_nz(p, regs.a); end
			OP_TSX: begin res.regs.x = regs.sp; p = set_nz(p, regs.sp); end
			OP_TXA: begin res.regs.a = regs.x; p = set_nz(p, regs.x); end
			OP_TXS: res.regs.sp = regs.x;
			OP_TYA: begin res.regs.a = regs.y; p = set_nz(p, regs.y); end
			OP_CLC: p = p & ~F_C;
			OP_CLD: p = p & ~F_D;
			OP_CLI: p = p & ~F_I;
			OP_CLV: p = p & ~F_V;
			OP_SEC: p = p | F_C;
			OP_SED: p = p | F_D;
			OP_SEI: p = p | F_I;
			OP_BCC: take = ~regs.p[0];
			OP_BCS: take = regs.p[0];
			OP_BEQ: take = regs.p[1];
			OP_BNE: take = ~regs.p[1];
			OP_BMI: take = regs.p[7];
			OP_BPL: take = ~regs.p[7];
			OP_BVC: take = ~regs.p[6];
			OP_BVS: take = regs.p[6];
			OP_JMP: res.regs.pc = jump_target;
			OP_STA: begin res.we = 1'b1; res.wd = regs.a; end
			OP_STX: begin res.we = 1'b1; res.wd = regs.x; end
			OP_STY: begin res.we = 1'b1; res.wd = regs.y; end
			default: ;
		endcase
		res.regs.p = p;
		if (take)
			res.regs.pc = next_pc + {{8{operand[7]}}, operand};
	end

endmodule

// ===== hw/rtl/cpu_8bit_execute_unit.sv =====
// Execute stage of an 8-bit 6502-style processor. Each input word is one decoded
// instruction; each produces exactly one output word with all registers, the new
// program counter and any memory write-back byte. Register-only instructions go
// straight from the ALU into the output register and may be issued back to back
// while results are taken. Stack instructions run a small sequencer over the stack
// RAM, which is never read and written at once: one step per pushed byte, a read
// step and a data step per pulled byte, and a done state that posts the result.
// A result waiting at the output holds off the next word, which can enter in the
// same cycle that the waiting result is taken. Configuration is written through
// an APB port at 4*index.
module cpu_8bit_execute_unit
	import cpu8_pkg::*;
#(
	parameter int STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// instruction channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  cmd,
	input  logic [7:0]  operand,
	input  logic [15:0] jump_target,
	input  logic [15:0] next_pc,
	input  logic        on_memory,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_enable,
	output logic [7:0]  write_data,
	output logic [7:0]  acc_out,
	output logic [7:0]  x_out,
	output logic [7:0]  y_out,
	output logic [7:0]  sp_out,
	output logic [7:0]  status_out,
	output logic [15:0] pc_out,
	output logic        halted
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// configuration registers
	logic [15:0] brk_vec_q;
	logic [15:0] rst_vec_q;
	logic        stop_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		unique case (cfg_idx)
			REG_BRK_VEC: prdata = {16'd0, brk_vec_q};
			REG_RST_VEC: prdata = {16'd0, rst_vec_q};
			REG_STOP:    prdata = {31'd0, stop_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_vec_q <= 16'd0;
			rst_vec_q <= 16'd0;
			stop_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BRK_VEC: brk_vec_q <= pwdata[15:0];
				REG_RST_VEC: rst_vec_q <= pwdata[15:0];
				REG_STOP:    stop_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// architectural state
	regs_t regs_q;
	regs_t regs_d;
	logic  regs_ld;

	// stack memory
	logic [7:0]    stk_mem [STACK_DEPTH];
	logic          stk_we;
	logic [AW-1:0] stk_waddr;
	logic [7:0]    stk_wdata;
	logic          stk_re;
	logic [AW-1:0] stk_raddr;
	logic [7:0]    stk_rdata_q;

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= stk_wdata;
		if (stk_re)
			stk_rdata_q <= stk_mem[stk_raddr];
	end

	// sequencer for stack instructions
	state_t      state_q, state_d;
	logic [5:0]  op_q;
	logic [15:0] npc_q;
	logic [15:0] tgt_q;
	logic [2:0]  step_q, step_d;
	logic [7:0]  lo_q, lo_d;
	regs_t       wrk_q, wrk_d;

	// output register
	logic        ov_q;
	logic        we_q;
	logic [7:0]  wd_q;
	regs_t       oregs_q;
	logic        halt_q;

	alu_res_t alu;
	logic     acc;
	logic     is_stack;
	logic     out_free;
	logic     fin;
	logic     fin_halt;
	logic [15:0] ret;

	cpu8_alu u_alu (
		.regs        (regs_q),
		.cmd         (cmd),
		.operand     (operand),
		.jump_target (jump_target),
		.next_pc     (next_pc),
		.on_memory   (on_memory),
		.res         (alu)
	);

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign acc      = in_valid && in_ready;

	always_comb begin
		unique case (cmd) inside
			OP_JSR, OP_RTS, OP_RTI, OP_PHA, OP_PHP, OP_PLA, OP_PLP: is_stack = 1'b1;
			OP_BRK:  is_stack = !stop_q;
			default: is_stack = 1'b0;
		endcase
	end

	// push: write at sp, then decrement; pull: increment, read at new sp
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		lo_d      = lo_q;
		wrk_d     = wrk_q;
		stk_we    = 1'b0;
		stk_waddr = wrk_q.sp[AW-1:0];
		stk_wdata = 8'd0;
		stk_re    = 1'b0;
		stk_raddr = wrk_q.sp[AW-1:0] + AW'(1);
		fin       = 1'b0;
		fin_halt  = 1'b0;
		ret       = 16'd0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && is_stack) begin
					state_d = ST_STACK;
					step_d  = 3'd0;
					wrk_d   = regs_q;
				end else if (acc) begin
					fin      = 1'b1;
					fin_halt = (cmd == OP_BRK);
				end
			end
			ST_STACK: begin
				step_d = step_q + 3'd1;
				unique case (op_q) inside
					OP_PHA, OP_PHP: begin
						stk_we = 1'b1;
						stk_wdata = (op_q == OP_PHA) ? wrk_q.a : wrk_q.p;
						wrk_d.sp = wrk_q.sp - 8'd1;
						wrk_d.pc = npc_q;
						state_d = ST_DONE;
					end
					OP_JSR, OP_BRK: begin
						ret = (op_q == OP_JSR) ? npc_q - 16'd1 : npc_q + 16'd1;
						stk_we = 1'b1;
						wrk_d.sp = wrk_q.sp - 8'd1;
						unique case (step_q)
							3'd0: stk_wdata = ret[15:8];
							3'd1: begin
								stk_wdata = ret[7:0];
								if (op_q == OP_JSR) begin
									wrk_d.pc = tgt_q;
									state_d = ST_DONE;
								end
							end
							default: begin
								stk_wdata = wrk_q.p | F_B;
								wrk_d.p = wrk_q.p | F_B | F_I;
								wrk_d.pc = brk_vec_q;
								state_d = ST_DONE;
							end
						endcase
					end
					default: begin
						// pulls: read issued on even steps, data back on odd steps
						if (!step_q[0]) begin
							stk_re = 1'b1;
							wrk_d.sp = wrk_q.sp + 8'd1;
						end else begin
							unique case (op_q) inside
								OP_PLA: begin
									wrk_d.a = stk_rdata_q;
									wrk_d.p = set_nz(wrk_q.p, stk_rdata_q);
									wrk_d.pc = npc_q;
									state_d = ST_DONE;
								end
								OP_PLP: begin
									wrk_d.p = stk_rdata_q;
									wrk_d.pc = npc_q;
									state_d = ST_DONE;
								end
								OP_RTS: begin
									if (step_q == 3'd1)
										lo_d = stk_rdata_q;
									else begin
										wrk_d.pc = {stk_rdata_q, lo_q} + 16'd1;
										state_d = ST_DONE;
									end
								end
								default: begin
									if (step_q == 3'd1)
										wrk_d.p = stk_rdata_q;
									else if (step_q == 3'd3)
										lo_d = stk_rdata_q;
									else begin
										wrk_d.pc = {stk_rdata_q, lo_q};
										state_d = ST_DONE;
									end
								end
							endcase
						end
					end
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		wrk_q <= wrk_d;
		if (acc) begin
			op_q  <= cmd;
			npc_q <= next_pc;
			tgt_q <= jump_target;
		end
	end

	// register file update
	always_comb begin
		regs_ld = fin;
		if (state_q == ST_DONE)
			regs_d = wrk_q;
		else if (fin_halt)
			regs_d = regs_q;
		else
			regs_d = alu.regs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: 8'hFF, p: F_I, pc: 16'd0};
		end else if (cfg_wr && cfg_idx == REG_RST_VEC) begin
			regs_q.pc <= pwdata[15:0];
		end else if (regs_ld) begin
			regs_q <= regs_d;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fin) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			oregs_q <= regs_d;
			halt_q  <= fin_halt;
			we_q    <= (state_q == ST_IDLE) && !fin_halt && alu.we;
			wd_q    <= ((state_q == ST_IDLE) && !fin_halt) ? alu.wd : 8'd0;
		end
	end

	assign out_valid    = ov_q;
	assign write_enable = we_q;
	assign write_data   = wd_q;
	assign acc_out      = oregs_q.a;
	assign x_out        = oregs_q.x;
	assign y_out        = oregs_q.y;
	assign sp_out       = oregs_q.sp;
	assign status_out   = oregs_q.p;
	assign pc_out       = oregs_q.pc;
	assign halted       = halt_q;

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("word accepted during stack sequence");
	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!ov_q || out_ready))
		else $error("result overwrote a pending word");
	a_no_mem_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(stk_we && stk_re))
		else $error("stack read and write in one cycle");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && ov_q))
		else $error("finished word not posted");
`endif

endmodule
